FILE: design/generational_handle_allocator_unit_defines.svh
// Assertion macros shared by the generational handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define GHA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true.
`define GHA_NEVER(name, expr, msg) \
  `GHA_ASSERT(name, !(expr), msg)

`endif

FILE: design/gha_pkg.sv
// Types and constants shared by the generational handle allocator modules.
`default_nettype none

package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int GEN_BITS   = 32;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = IDX_W + 1;
  localparam int GEN_W   = 32;
  localparam int WORLD_W = 16;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int LEASE_W = 16;

  localparam logic [GEN_BITS-1:0] GEN_MAX   = {GEN_BITS{1'b1}};
  localparam logic [LEASE_W-1:0]  LEASE_MAX = {LEASE_W{1'b1}};
  localparam logic [WORLD_W-1:0]  WORLD_RESET = WORLD_W'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_COMMIT  = 3'd2,
    ACT_CHECK   = 3'd3,
    ACT_ACQUIRE = 3'd4,
    ACT_RELEASE = 3'd5
  } gha_action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_LEASED  = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } gha_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CR_POP,
    S_CR_GEN,
    S_SLOT_EVAL,
    S_CMT_SLOT,
    S_CMT_EVAL,
    S_RESP
  } gha_state_e;

  // One slot table entry.
  typedef struct packed {
    logic                live;
    logic                queued;
    logic [GEN_BITS-1:0] gen;
  } gha_slot_t;

  // Result of the shared generation compare and increment unit.
  typedef struct packed {
    logic                eq;
    logic                at_max;
    logic [GEN_BITS-1:0] inc;
  } gha_gen_res_t;

endpackage

`default_nettype wire

FILE: design/gha_slot_ram.sv
// Slot table memory: live bit, queued bit and generation of every slot.
`default_nettype none

module gha_slot_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [gha_pkg::IDX_W-1:0]     waddr_i,
  input  gha_pkg::gha_slot_t            wdata_i,
  input  logic                          re_i,
  input  logic [gha_pkg::IDX_W-1:0]     raddr_i,
  output gha_pkg::gha_slot_t            rdata_o
);
  import gha_pkg::*;

  gha_slot_t mem [SLOT_COUNT];
  gha_slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/gha_idx_ram.sv
// Slot index memory, used for the free stack and for the release queue.
`default_nettype none

module gha_idx_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [gha_pkg::IDX_W-1:0] waddr_i,
  input  logic [gha_pkg::IDX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [gha_pkg::IDX_W-1:0] raddr_i,
  output logic [gha_pkg::IDX_W-1:0] rdata_o
);
  import gha_pkg::*;

  logic [IDX_W-1:0] mem [SLOT_COUNT];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/gha_gen_unit.sv
// Shared generation unit: compares a stored generation and computes its successor.
`default_nettype none

module gha_gen_unit (
  input  logic [gha_pkg::GEN_BITS-1:0] stored_i,
  input  logic [gha_pkg::GEN_W-1:0]    handle_gen_i,
  output gha_pkg::gha_gen_res_t        res_o
);
  import gha_pkg::*;

  always_comb begin
    res_o.eq     = (GEN_W'(stored_i) == handle_gen_i);
    res_o.at_max = (stored_i == GEN_MAX);
    res_o.inc    = stored_i + GEN_BITS'(1);
  end

endmodule

`default_nettype wire

FILE: design/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator.
`default_nettype none

`include "generational_handle_allocator_unit_defines.svh"

// Generational handle allocator. One beat is taken at a time: the input stalls
// from acceptance until the result has been moved into the output register,
// and the output register may still hold an earlier result while a new beat is
// taken. All slot state lives in one slot table with a read and a write port,
// so every action is a short sequence of table reads and writes. Lease actions,
// refused actions and fresh creates go straight to the response step; check
// and destroy first read the slot, create from the free stack pops an index,
// reads the slot and writes it back, and commit walks the queued slots: each
// needs one queue read and one read-modify-write of the slot table. The table
// needs no clearing after reset: a check or destroy may read an entry at or
// above the fresh-slot counter, but the range test keeps it out of the result.
module generational_handle_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gha_pkg::WORLD_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gha_pkg::ACT_W-1:0]    action_i,
  input  logic [gha_pkg::WORLD_W-1:0]  handle_world_i,
  input  logic [gha_pkg::IDX_W-1:0]    handle_index_i,
  input  logic [gha_pkg::GEN_W-1:0]    handle_generation_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gha_pkg::STAT_W-1:0]   status_o,
  output logic [gha_pkg::IDX_W-1:0]    new_index_o,
  output logic [gha_pkg::GEN_W-1:0]    new_generation_o,
  output logic                         is_live_o
);
  import gha_pkg::*;

  gha_state_e state_q, state_d;

  logic [WORLD_W-1:0] world_tag_q;
  logic [ACT_W-1:0]   act_q;
  logic [WORLD_W-1:0] world_in_q;
  logic [IDX_W-1:0]   idx_in_q;
  logic [GEN_W-1:0]   hgen_q;

  logic [CNT_W-1:0]   fc_q, fc_d;
  logic [CNT_W-1:0]   rc_q, rc_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;
  logic [LEASE_W-1:0] lease_q, lease_d;
  logic [IDX_W-1:0]   walk_q, walk_d;
  logic [IDX_W-1:0]   cur_slot_q, cur_slot_d;

  gha_status_e        res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [GEN_W-1:0]   res_gen_q, res_gen_d;
  logic               res_live_q, res_live_d;

  logic               out_valid_q;
  gha_status_e        out_status_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [GEN_W-1:0]   out_gen_q;
  logic               out_live_q;

  logic               slot_we, slot_re;
  logic [IDX_W-1:0]   slot_waddr, slot_raddr;
  gha_slot_t          slot_wdata, slot_rd;
  logic               fs_we, fs_re;
  logic [IDX_W-1:0]   fs_waddr, fs_raddr, fs_wdata, fs_rd;
  logic               rq_we, rq_re;
  logic [IDX_W-1:0]   rq_waddr, rq_raddr, rq_wdata, rq_rd;
  gha_gen_res_t       gen_res;

  logic               accept, out_free, out_load;
  logic               lease_busy, fs_nonempty, fresh_ok, handle_ok;
  logic [CNT_W-1:0]   fc_dec, walk_nxt;
  logic               walk_last;

  gha_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd)
  );

  gha_idx_ram u_free_stack (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rd)
  );

  gha_idx_ram u_release_queue (
    .clk_i   (clk_i),
    .we_i    (rq_we),
    .waddr_i (rq_waddr),
    .wdata_i (rq_wdata),
    .re_i    (rq_re),
    .raddr_i (rq_raddr),
    .rdata_o (rq_rd)
  );

  gha_gen_unit u_gen_unit (
    .stored_i     (slot_rd.gen),
    .handle_gen_i (hgen_q),
    .res_o        (gen_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_RESP) && out_free;

  assign lease_busy  = (lease_q != '0);
  assign fs_nonempty = (fc_q != '0);
  assign fresh_ok    = (fresh_q < CNT_W'(SLOT_COUNT));
  assign fc_dec      = fc_q - CNT_W'(1);
  assign walk_nxt    = CNT_W'(walk_q) + CNT_W'(1);
  assign walk_last   = (walk_nxt == rc_q);

  // The range test keeps reads of never-written table entries out of the result.
  assign handle_ok = (world_in_q == world_tag_q) && (idx_in_q != '0) &&
                     (CNT_W'(idx_in_q) < fresh_q) && slot_rd.live && gen_res.eq;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (act_q)
          ACT_CREATE: begin
            if (!lease_busy && fs_nonempty) state_d = S_CR_POP;
            else state_d = S_RESP;
          end
          ACT_DESTROY: begin
            state_d = lease_busy ? S_RESP : S_SLOT_EVAL;
          end
          ACT_CHECK: begin
            state_d = S_SLOT_EVAL;
          end
          ACT_COMMIT: begin
            if (lease_busy || rc_q == '0) state_d = S_RESP;
            else state_d = S_CMT_SLOT;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_CR_POP:    state_d = S_CR_GEN;
      S_CR_GEN:    state_d = S_RESP;
      S_SLOT_EVAL: state_d = S_RESP;
      S_CMT_SLOT:  state_d = S_CMT_EVAL;
      S_CMT_EVAL: begin
        state_d = walk_last ? S_RESP : S_CMT_SLOT;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    fc_d         = fc_q;
    rc_d         = rc_q;
    fresh_d      = fresh_q;
    lease_d      = lease_q;
    walk_d       = walk_q;
    cur_slot_d   = cur_slot_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_gen_d    = res_gen_q;
    res_live_d   = res_live_q;
    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = '0;
    fs_we        = 1'b0;
    fs_waddr     = '0;
    fs_wdata     = '0;
    fs_re        = 1'b0;
    fs_raddr     = '0;
    rq_we        = 1'b0;
    rq_waddr     = '0;
    rq_wdata     = '0;
    rq_re        = 1'b0;
    rq_raddr     = '0;

    case (state_q)
      S_DISPATCH: begin
        res_status_d = STAT_OK;
        res_idx_d    = '0;
        res_gen_d    = '0;
        res_live_d   = 1'b0;
        case (act_q)
          ACT_CREATE: begin
            if (lease_busy) begin
              res_status_d = STAT_LEASED;
            end else if (fs_nonempty) begin
              fs_re    = 1'b1;
              fs_raddr = fc_dec[IDX_W-1:0];
              fc_d     = fc_dec;
            end else if (fresh_ok) begin
              slot_we    = 1'b1;
              slot_waddr = fresh_q[IDX_W-1:0];
              slot_wdata = '{live: 1'b1, queued: 1'b0, gen: GEN_BITS'(1)};
              res_idx_d  = fresh_q[IDX_W-1:0];
              res_gen_d  = GEN_W'(1);
              fresh_d    = fresh_q + CNT_W'(1);
            end else begin
              res_status_d = STAT_FULL;
            end
          end
          ACT_DESTROY: begin
            if (lease_busy) begin
              res_status_d = STAT_LEASED;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = idx_in_q;
            end
          end
          ACT_CHECK: begin
            slot_re    = 1'b1;
            slot_raddr = idx_in_q;
          end
          ACT_COMMIT: begin
            if (lease_busy) begin
              res_status_d = STAT_LEASED;
            end else if (rc_q != '0) begin
              rq_re    = 1'b1;
              rq_raddr = '0;
              walk_d   = '0;
            end
          end
          ACT_ACQUIRE: begin
            if (lease_q != LEASE_MAX) lease_d = lease_q + LEASE_W'(1);
          end
          ACT_RELEASE: begin
            if (lease_busy) lease_d = lease_q - LEASE_W'(1);
          end
          default: begin
          end
        endcase
      end
      S_CR_POP: begin
        cur_slot_d = fs_rd;
        slot_re    = 1'b1;
        slot_raddr = fs_rd;
      end
      S_CR_GEN: begin
        slot_we    = 1'b1;
        slot_waddr = cur_slot_q;
        slot_wdata = '{live: 1'b1, queued: 1'b0, gen: slot_rd.gen};
        res_idx_d  = cur_slot_q;
        res_gen_d  = GEN_W'(slot_rd.gen);
      end
      S_SLOT_EVAL: begin
        if (act_q == ACT_CHECK) begin
          if (handle_ok) res_live_d = 1'b1;
          else res_status_d = STAT_INVALID;
        end else if (!handle_ok) begin
          res_status_d = STAT_INVALID;
        end else if (!slot_rd.queued && rc_q < CNT_W'(SLOT_COUNT)) begin
          // A slot already waiting for release is not queued a second time.
          rq_we      = 1'b1;
          rq_waddr   = rc_q[IDX_W-1:0];
          rq_wdata   = idx_in_q;
          rc_d       = rc_q + CNT_W'(1);
          slot_we    = 1'b1;
          slot_waddr = idx_in_q;
          slot_wdata = '{live: 1'b1, queued: 1'b1, gen: slot_rd.gen};
        end
      end
      S_CMT_SLOT: begin
        cur_slot_d = rq_rd;
        slot_re    = 1'b1;
        slot_raddr = rq_rd;
      end
      S_CMT_EVAL: begin
        slot_we    = 1'b1;
        slot_waddr = cur_slot_q;
        slot_wdata = '{live: 1'b0, queued: 1'b0,
                       gen: gen_res.at_max ? slot_rd.gen : gen_res.inc};
        // A slot at the last generation is retired and never freed again.
        if (!gen_res.at_max && fc_q < CNT_W'(SLOT_COUNT)) begin
          fs_we    = 1'b1;
          fs_waddr = fc_q[IDX_W-1:0];
          fs_wdata = cur_slot_q;
          fc_d     = fc_q + CNT_W'(1);
        end
        if (walk_last) begin
          rc_d = '0;
        end else begin
          rq_re    = 1'b1;
          rq_raddr = walk_nxt[IDX_W-1:0];
          walk_d   = walk_nxt[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      world_tag_q <= WORLD_RESET;
      fc_q        <= '0;
      rc_q        <= '0;
      fresh_q     <= CNT_W'(1);
      lease_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      rc_q    <= rc_d;
      fresh_q <= fresh_d;
      lease_q <= lease_d;
      walk_q  <= walk_d;
      if (cfg_we_i) world_tag_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= action_i;
      world_in_q <= handle_world_i;
      idx_in_q   <= handle_index_i;
      hgen_q     <= handle_generation_i;
    end
    cur_slot_q   <= cur_slot_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_gen_q    <= res_gen_d;
    res_live_q   <= res_live_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_gen_q    <= res_gen_q;
      out_live_q   <= res_live_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign new_index_o      = out_idx_q;
  assign new_generation_o = out_gen_q;
  assign is_live_o        = out_live_q;

  `GHA_ASSERT(a_free_below_fresh, (fc_q < fresh_q), "free stack holds more slots than exist")
  `GHA_ASSERT(a_queue_below_fresh, (rc_q < fresh_q), "release queue holds more slots than exist")
  `GHA_ASSERT(a_result_from_resp, $rose(out_valid_q) |-> $past(state_q == S_RESP), "result beat without response step")
  `GHA_NEVER(a_commit_no_lease, (state_q == S_CMT_EVAL) && lease_busy, "commit walk while leases held")
  `GHA_ASSERT(a_create_nonzero, (out_valid_q && out_gen_q != '0) |-> (out_idx_q != '0), "created handle uses slot zero")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the generational handle allocator: random and directed beats vs a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN_HI = 3'd7;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    gha_status_e        status;
    logic [IDX_W-1:0]   index;
    logic [GEN_W-1:0]   generation;
    logic               live;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WORLD_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ACT_W-1:0]    action_i = '0;
  logic [WORLD_W-1:0]  handle_world_i = '0;
  logic [IDX_W-1:0]    handle_index_i = '0;
  logic [GEN_W-1:0]    handle_generation_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [IDX_W-1:0]    new_index_o;
  logic [GEN_W-1:0]    new_generation_o;
  logic                is_live_o;

  generational_handle_allocator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .handle_world_i     (handle_world_i),
    .handle_index_i     (handle_index_i),
    .handle_generation_i(handle_generation_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .new_index_o        (new_index_o),
    .new_generation_o   (new_generation_o),
    .is_live_o          (is_live_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Allocator state as the predictor sees it.
  logic [WORLD_W-1:0] world_reg = WORLD_RESET;
  logic [GEN_W-1:0]   gen_tbl [SLOT_COUNT];
  bit                 live_tbl [SLOT_COUNT];
  bit                 queued_tbl [SLOT_COUNT];
  logic [IDX_W-1:0]   free_stk [SLOT_COUNT];
  logic [CNT_W-1:0]   free_depth = '0;
  logic [IDX_W-1:0]   pending_rel [SLOT_COUNT];
  logic [CNT_W-1:0]   pending_depth = '0;
  logic [CNT_W-1:0]   fresh_slot = CNT_W'(1);
  logic [LEASE_W-1:0] leases = '0;

  alloc_result_t expected_results [$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  beats_sent = 0;
  int  action_count [8];
  int  full_refusals = 0;
  int  live_hits = 0;
  int  world_writes = 0;
  int  idle_cycles = 0;
  logic [IDX_W-1:0] last_made_index = '0;

  bit  offering = 1'b0;
  bit  tx_gaps_on = 1'b1;
  int  burst_left = 0;
  logic hold_request = 1'b0;
  logic rx_quiet = 1'b0;
  int  hold_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;

  function automatic bit handle_is_valid(input logic [WORLD_W-1:0] w,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [GEN_W-1:0] g);
    return w == world_reg && idx != 0 && CNT_W'(idx) < fresh_slot &&
           live_tbl[idx] && gen_tbl[idx] == g;
  endfunction

  function automatic alloc_result_t predict_allocation(input logic [ACT_W-1:0] act,
                                                       input logic [WORLD_W-1:0] w,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [GEN_W-1:0] g);
    alloc_result_t r;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (act)
      ACT_CREATE: begin
        if (leases != 0) begin
          r.status = STAT_LEASED;
        end else if (free_depth != 0 || fresh_slot < SLOT_COUNT) begin
          if (free_depth != 0) begin
            free_depth--;
            slot = free_stk[free_depth];
          end else begin
            slot = fresh_slot[IDX_W-1:0];
            fresh_slot++;
            gen_tbl[slot] = GEN_W'(1);
          end
          live_tbl[slot] = 1'b1;
          queued_tbl[slot] = 1'b0;
          r.index = slot;
          r.generation = gen_tbl[slot];
        end else begin
          r.status = STAT_FULL;
        end
      end
      ACT_DESTROY: begin
        // The lease test takes priority over the handle test.
        if (leases != 0) begin
          r.status = STAT_LEASED;
        end else if (!handle_is_valid(w, idx, g)) begin
          r.status = STAT_INVALID;
        end else if (!queued_tbl[idx] && pending_depth < SLOT_COUNT) begin
          pending_rel[pending_depth] = idx;
          pending_depth++;
          queued_tbl[idx] = 1'b1;
        end
      end
      ACT_COMMIT: begin
        if (leases != 0) begin
          r.status = STAT_LEASED;
        end else begin
          for (int i = 0; i < int'(pending_depth); i++) begin
            slot = pending_rel[i];
            live_tbl[slot] = 1'b0;
            queued_tbl[slot] = 1'b0;
            // A slot at the generation ceiling is retired rather than freed.
            if (gen_tbl[slot] != GEN_MAX) begin
              gen_tbl[slot]++;
              if (free_depth < SLOT_COUNT) begin
                free_stk[free_depth] = slot;
                free_depth++;
              end
            end
          end
          pending_depth = '0;
        end
      end
      ACT_CHECK: begin
        if (handle_is_valid(w, idx, g)) r.live = 1'b1;
        else r.status = STAT_INVALID;
      end
      ACT_ACQUIRE: begin
        if (leases != LEASE_MAX) leases++;
      end
      ACT_RELEASE: begin
        if (leases != 0) leases--;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] find_live_slot();
    int span;
    int start;
    int s;
    span = int'(fresh_slot) - 1;
    if (span <= 0) return '0;
    start = $urandom_range(0, span - 1);
    for (int k = 0; k < span; k++) begin
      s = 1 + (start + k) % span;
      if (live_tbl[s]) return s[IDX_W-1:0];
    end
    return '0;
  endfunction

  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [WORLD_W-1:0] w,
                           input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] g);
    alloc_result_t r;
    int gap;
    in_valid_i <= 1'b1;
    action_i <= act;
    handle_world_i <= w;
    handle_index_i <= idx;
    handle_generation_i <= g;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_allocation(act, w, idx, g);
    expected_results.insert(expected_results.size(), r);
    beats_sent++;
    action_count[act]++;
    if (r.status == STAT_FULL) full_refusals++;
    if (r.live) live_hits++;
    last_made_index = r.index;
    if (tx_gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
        in_valid_i <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Actions whose handle fields carry no meaning still get random bits.
  task automatic send_plain(input logic [ACT_W-1:0] act);
    send_beat(act, WORLD_W'($urandom), IDX_W'($urandom), GEN_W'($urandom));
  endtask

  // Mostly handles of live slots; the rest are stale, from another world or random.
  task automatic send_handle_op(input logic [ACT_W-1:0] act);
    logic [IDX_W-1:0] slot;
    logic [WORLD_W-1:0] w;
    logic [GEN_W-1:0] g;
    int flavor;
    slot = find_live_slot();
    flavor = $urandom_range(0, 9);
    w = world_reg;
    g = '0;
    if (slot != 0) g = gen_tbl[slot];
    if (slot == 0 || flavor == 9) begin
      if ($urandom_range(0, 1) == 0) w = WORLD_W'($urandom);
      slot = IDX_W'($urandom);
      g = GEN_W'($urandom);
    end else if (flavor == 8) begin
      w = world_reg ^ (WORLD_W'(1) << $urandom_range(0, WORLD_W - 1));
    end else if (flavor == 7) begin
      slot = IDX_W'($urandom_range(1, int'(fresh_slot) - 1));
      g = gen_tbl[slot] + $urandom_range(0, 2) - 1;
    end
    send_beat(act, w, slot, g);
  endtask

  task automatic wait_for_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_world(input logic [WORLD_W-1:0] tag);
    wait_for_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tag;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    world_reg = tag;
    world_writes++;
  endtask

  task automatic test_directed();
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    send_beat(ACT_CHECK, world_reg, '0, '0);
    send_beat(ACT_CHECK, world_reg, IDX_W'(1), GEN_W'(1));
    send_beat(ACT_DESTROY, world_reg, IDX_W'(1), GEN_W'(1));
    send_plain(ACT_COMMIT);
    send_plain(ACT_CREATE);
    first = last_made_index;
    send_plain(ACT_CREATE);
    second = last_made_index;
    send_beat(ACT_CHECK, world_reg, first, gen_tbl[first]);
    send_beat(ACT_CHECK, ~world_reg, first, gen_tbl[first]);
    send_beat(ACT_CHECK, world_reg, first, gen_tbl[first] + 1);
    send_beat(ACT_CHECK, '1, '1, '1);
    send_beat(ACT_DESTROY, world_reg, first, gen_tbl[first]);
    // A second destroy of a queued slot is accepted but not queued again.
    send_beat(ACT_DESTROY, world_reg, first, gen_tbl[first]);
    send_beat(ACT_CHECK, world_reg, first, gen_tbl[first]);
    send_plain(ACT_COMMIT);
    send_beat(ACT_CHECK, world_reg, first, gen_tbl[first] - 1);
    send_beat(ACT_DESTROY, world_reg, first, gen_tbl[first] - 1);
    send_plain(ACT_CREATE);
    send_plain(ACT_ACQUIRE);
    send_plain(ACT_CREATE);
    send_beat(ACT_DESTROY, '0, '0, '0);
    send_plain(ACT_COMMIT);
    send_beat(ACT_CHECK, world_reg, second, gen_tbl[second]);
    send_plain(ACT_RELEASE);
    send_plain(ACT_RELEASE);
    send_plain(ACT_UNKNOWN_LO);
    send_plain(ACT_UNKNOWN_HI);
  endtask

  task automatic test_world_settings();
    logic [WORLD_W-1:0] tag_values [2] = '{WORLD_W'(0), '1};
    logic [IDX_W-1:0] slot;
    foreach (tag_values[i]) begin
      write_world(tag_values[i]);
      send_plain(ACT_CREATE);
      slot = last_made_index;
      send_beat(ACT_CHECK, tag_values[i], slot, gen_tbl[slot]);
      send_beat(ACT_CHECK, ~tag_values[i], slot, gen_tbl[slot]);
      send_beat(ACT_DESTROY, tag_values[i], slot, gen_tbl[slot]);
      send_plain(ACT_COMMIT);
      send_beat(ACT_CHECK, tag_values[i], slot, gen_tbl[slot]);
    end
  endtask

  task automatic test_random_traffic(input int beats, input logic [WORLD_W-1:0] tag);
    int pick;
    write_world(tag);
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_plain(ACT_CREATE);
      else if (pick < 55) send_handle_op(ACT_DESTROY);
      else if (pick < 62) send_plain(ACT_COMMIT);
      else if (pick < 82) send_handle_op(ACT_CHECK);
      else if (pick < 87) send_plain(ACT_ACQUIRE);
      else if (pick < 94) send_plain(ACT_RELEASE);
      else if (pick < 97) send_plain($urandom_range(0, 1) ? ACT_UNKNOWN_LO : ACT_UNKNOWN_HI);
      else send_plain(ACT_W'($urandom));
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming, then the
  // sender waits for every outstanding result before going on.
  task automatic test_backpressure();
    wait_for_results();
    tx_gaps_on = 1'b0;
    hold_request <= 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_plain(ACT_CREATE);
      else send_handle_op(ACT_CHECK);
    end
    tx_gaps_on = 1'b1;
    wait_for_results();
  endtask

  // Fills every slot, then frees a handful so creates succeed again.
  task automatic test_capacity();
    int destroyed;
    destroyed = 0;
    while (leases != 0) send_plain(ACT_RELEASE);
    while (free_depth != 0 || fresh_slot < SLOT_COUNT) send_plain(ACT_CREATE);
    repeat (3) send_plain(ACT_CREATE);
    for (int s = 1; s < SLOT_COUNT && destroyed < 16; s++) begin
      if (live_tbl[s] && !queued_tbl[s]) begin
        send_beat(ACT_DESTROY, world_reg, s[IDX_W-1:0], gen_tbl[s]);
        destroyed++;
      end
    end
    send_plain(ACT_COMMIT);
    repeat (12) send_plain(ACT_CREATE);
  endtask

  task automatic test_lease_saturation();
    wait_for_results();
    tx_gaps_on = 1'b0;
    rx_quiet <= 1'b1;
    repeat (3) send_plain(ACT_ACQUIRE);
    send_plain(ACT_CREATE);
    send_plain(ACT_COMMIT);
    repeat (4) send_plain(ACT_RELEASE);
    // Only succeeds if the release at zero left the lease count alone.
    send_plain(ACT_CREATE);
    send_plain(ACT_ACQUIRE);
    send_plain(ACT_CREATE);
    send_plain(ACT_RELEASE);
    rx_quiet <= 1'b0;
    tx_gaps_on = 1'b1;
  endtask

  // Receiver stall pattern; switches between randomly chosen styles.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 4) < 3);
        default: out_stall_i <= (rx_cycle % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected result beat: status %0d index %0d gen %0h live %0b",
                   status_o, new_index_o, new_generation_o, is_live_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || new_index_o !== want.index ||
            new_generation_o !== want.generation || is_live_o !== want.live) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch on result %0d: expected status %0d index %0d gen %0h live %0b",
                     results_checked, want.status, want.index, want.generation, want.live);
            $display("  got status %0d index %0d gen %0h live %0b",
                     status_o, new_index_o, new_generation_o, is_live_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int failures;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_world_settings();
    test_random_traffic(400, WORLD_W'($urandom));
    test_backpressure();
    test_capacity();
    test_random_traffic(100, WORLD_RESET);
    test_lease_saturation();
    wait_for_results();
    failures = mismatches + expected_results.size();
    $display("Run covered %0d beats: %0d creates (%0d refused as full), %0d destroys,",
             beats_sent, action_count[ACT_CREATE], full_refusals, action_count[ACT_DESTROY]);
    $display("  %0d commits, %0d checks (%0d live), %0d leases taken, %0d world tags; %0d bad",
             action_count[ACT_COMMIT], action_count[ACT_CHECK], live_hits,
             action_count[ACT_ACQUIRE], world_writes, failures);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
